[hw/rtl/dwrl_pkg.sv]
// Shared constants, types and helper functions for the dual window rate limiter.
package dwrl_pkg;

    localparam int FLOW_SLOTS = 4096;
    localparam int TIME_BITS  = 40;
    localparam int SLOT_AW    = $clog2(FLOW_SLOTS);
    localparam int SLOT_W     = 12;
    localparam int NOW_W      = 40;
    localparam int CNT_W      = 16;
    localparam int TOT_W      = 32;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_W-1:0] RST_BURST_WIN  = 16'd1000;
    localparam logic [CFG_W-1:0] RST_BURST_LIM  = 16'd10;
    localparam logic [CFG_W-1:0] RST_BURST_BLK  = 16'd1000;
    localparam logic [CFG_W-1:0] RST_SUST_WIN   = 16'd10000;
    localparam logic [CFG_W-1:0] RST_SUST_LIM   = 16'd30;
    localparam logic [CFG_W-1:0] RST_SUST_BLK   = 16'd5000;
    localparam logic [CFG_W-1:0] RST_REP_INIT   = 16'd1000;
    localparam logic [CFG_W-1:0] RST_REP_MAX    = 16'd60000;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [SLOT_AW-1:0]   t_slot_idx;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BURST_WIN = 3'd0,
        CFG_BURST_LIM = 3'd1,
        CFG_BURST_BLK = 3'd2,
        CFG_SUST_WIN  = 3'd3,
        CFG_SUST_LIM  = 3'd4,
        CFG_SUST_BLK  = 3'd5,
        CFG_REP_INIT  = 3'd6,
        CFG_REP_MAX   = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        OP_CHECK  = 1'b0,
        OP_RECORD = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic [CFG_W-1:0] burst_win;
        logic [CFG_W-1:0] burst_lim;
        logic [CFG_W-1:0] burst_blk;
        logic [CFG_W-1:0] sust_win;
        logic [CFG_W-1:0] sust_lim;
        logic [CFG_W-1:0] sust_blk;
        logic [CFG_W-1:0] rep_init;
        logic [CFG_W-1:0] rep_max;
    } t_cfg;

    typedef struct packed {
        t_time            burst_start;
        logic [CNT_W-1:0] burst_count;
        t_time            sust_start;
        logic [CNT_W-1:0] sust_count;
        t_time            blocked_until;
        logic [CNT_W-1:0] report_delay;
        t_time            next_report;
        logic [TOT_W-1:0] block_total;
        logic [TOT_W-1:0] supp_total;
    } t_flow_rec;

    typedef struct packed {
        logic      re;
        t_slot_idx raddr;
        logic      we;
        t_slot_idx waddr;
    } t_tbl_req;

    typedef struct packed {
        logic             blocked;
        logic             should_report;
        logic [TOT_W-1:0] blocked_events;
        logic [TOT_W-1:0] suppressed_reports;
    } t_result;

    function automatic logic [CNT_W-1:0] sat_inc_cnt(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [TOT_W-1:0] sat_inc_tot(input logic [TOT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // t + d, clamped at the top of the time range
    function automatic t_time time_add(input t_time t, input logic [CNT_W-1:0] d);
        logic [TIME_BITS:0] s;
        s = {1'b0, t} + (TIME_BITS + 1)'(d);
        return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
    endfunction

    // unused start, or elapsed time reached the window length
    function automatic logic win_expired(input t_time start, input t_time now,
                                         input logic [CFG_W-1:0] len);
        return (start == '0) || ((now >= start) && ((now - start) >= t_time'(len)));
    endfunction

endpackage

[hw/rtl/dual_window_rate_limiter_unit.sv]
// Top level of the dual window per-flow rate limiter.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+-----------------------------------
//  in       | sink      | i_in_valid / o_in_ready      | i_op, i_slot, i_now_ms
//  out      | source    | o_out_valid / i_out_ready    | o_blocked, o_should_report,
//           |           |                              | o_blocked_events, o_suppressed_reports
//  cfg      | sink      | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_wdata
//
//  Each item passes table read, evaluate, then update and write back. The
//  single read-modify-write of the flow table sets the rate: one item is in
//  flight at a time, so accesses to one slot never overlap.
//  After reset a zeroing sweep walks all FLOW_SLOTS (4096) entries, one entry a
//  cycle; no input transfer is taken meanwhile. Config writes are taken at any
//  time. Reset is synchronous, active low.
//  A result waits in the output register; the next item is accepted and
//  read meanwhile, and only the update step stalls while that register is full.
module dual_window_rate_limiter_unit
    import dwrl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    // input items
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_op,
    input  logic [SLOT_W-1:0]    i_slot,
    input  logic [NOW_W-1:0]     i_now_ms,
    // result items
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_blocked,
    output logic                 o_should_report,
    output logic [TOT_W-1:0]     o_blocked_events,
    output logic [TOT_W-1:0]     o_suppressed_reports
);

    t_cfg      cfg;
    t_tbl_req  tbl_req;
    t_flow_rec tbl_rdata;
    t_flow_rec tbl_wdata;
    logic      tbl_busy;
    logic      out_free;
    logic      push;
    t_result   result;

    logic      r_out_valid;
    t_result   r_out;

    dwrl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    dwrl_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .i_wdata (tbl_wdata),
        .o_rdata (tbl_rdata),
        .o_busy  (tbl_busy)
    );

    dwrl_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_op       (i_op),
        .i_slot     (i_slot),
        .i_now_ms   (i_now_ms),
        .i_tbl_busy (tbl_busy),
        .i_rdata    (tbl_rdata),
        .o_req      (tbl_req),
        .o_wdata    (tbl_wdata),
        .i_out_free (out_free),
        .o_push     (push),
        .o_result   (result)
    );

    // output register: free when empty or being drained this cycle
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= result;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_blocked            = r_out.blocked;
    assign o_should_report      = r_out.should_report;
    assign o_blocked_events     = r_out.blocked_events;
    assign o_suppressed_reports = r_out.suppressed_reports;

`ifndef SYNTHESIS
    // one item in flight: ready drops right after a transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in flight");

    // no item enters while the table is being zeroed
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> !tbl_busy)
        else $error("input transfer during table sweep");

    // table write only together with a result into a free output register
    a_write_with_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_req.we |-> (push && out_free))
        else $error("table write without result push");

    // counts are shown only with a report, and never with a block verdict
    a_quiet_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_should_report) |->
        (o_blocked_events == '0 && o_suppressed_reports == '0))
        else $error("counts shown without a report");

    a_report_not_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_blocked && o_should_report))
        else $error("blocked and report both set");
`endif

endmodule

[hw/rtl/dwrl_cfg.sv]
// Configuration register bank of the rate limiter.
module dwrl_cfg
    import dwrl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.burst_win <= RST_BURST_WIN;
            r_cfg.burst_lim <= RST_BURST_LIM;
            r_cfg.burst_blk <= RST_BURST_BLK;
            r_cfg.sust_win  <= RST_SUST_WIN;
            r_cfg.sust_lim  <= RST_SUST_LIM;
            r_cfg.sust_blk  <= RST_SUST_BLK;
            r_cfg.rep_init  <= RST_REP_INIT;
            r_cfg.rep_max   <= RST_REP_MAX;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BURST_WIN: r_cfg.burst_win <= i_cfg_wdata;
                CFG_BURST_LIM: r_cfg.burst_lim <= i_cfg_wdata;
                CFG_BURST_BLK: r_cfg.burst_blk <= i_cfg_wdata;
                CFG_SUST_WIN:  r_cfg.sust_win  <= i_cfg_wdata;
                CFG_SUST_LIM:  r_cfg.sust_lim  <= i_cfg_wdata;
                CFG_SUST_BLK:  r_cfg.sust_blk  <= i_cfg_wdata;
                CFG_REP_INIT:  r_cfg.rep_init  <= i_cfg_wdata;
                CFG_REP_MAX:   r_cfg.rep_max   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/dwrl_table.sv]
// Per-flow state memory with a zeroing sweep after reset.
module dwrl_table
    import dwrl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_tbl_req  i_req,
    input  t_flow_rec i_wdata,
    output t_flow_rec o_rdata,
    output logic      o_busy
);

    localparam t_slot_idx LAST_IDX = SLOT_AW'(FLOW_SLOTS - 1);

    t_flow_rec mem [FLOW_SLOTS];
    t_flow_rec r_rdata;
    logic      r_clr_busy;
    t_slot_idx r_clr_addr;

    logic      wr_en;
    t_slot_idx wr_addr;
    t_flow_rec wr_data;

    // sweep owns the write port until every entry is zero
    always_comb begin
        wr_en   = r_clr_busy | i_req.we;
        wr_addr = r_clr_busy ? r_clr_addr : i_req.waddr;
        wr_data = r_clr_busy ? '0 : i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == LAST_IDX) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr_busy;

endmodule

[hw/rtl/dwrl_core.sv]
// Sequencer and read-modify-write datapath for one flow record.
module dwrl_core
    import dwrl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_op,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [NOW_W-1:0] i_now_ms,
    input  logic             i_tbl_busy,
    input  t_flow_rec        i_rdata,
    output t_tbl_req         o_req,
    output t_flow_rec        o_wdata,
    input  logic             i_out_free,
    output logic             o_push,
    output t_result          o_result
);

    t_state r_state, n_state;
    logic   accept;

    // item registers
    logic      r_op;
    t_slot_idx r_idx;
    t_time     r_now;

    // evaluate stage registers
    t_flow_rec r_rec;
    logic      r_b_exp, r_s_exp, r_blk_active, r_rep_hold;
    t_time     r_t_bblk, r_t_sblk, r_t_rep;

    logic [CNT_W-1:0] rdelay;
    t_flow_rec        ev_rec;
    t_flow_rec        upd_rec;
    t_result          upd_res;
    logic [CNT_W-1:0] b_cnt, s_cnt;
    logic             over_b, over_s;
    logic [CNT_W:0]   dbl;
    logic [TOT_W-1:0] bt;

    assign o_in_ready = (r_state == ST_IDLE) && !i_tbl_busy;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        o_req   = '0;
        o_req.raddr = SLOT_AW'(i_slot % FLOW_SLOTS);
        o_req.waddr = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                o_req.re = accept;
                if (accept) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (i_out_free) begin
                    o_req.we = 1'b1;
                    o_push   = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_op;
            r_idx <= SLOT_AW'(i_slot % FLOW_SLOTS);
            r_now <= TIME_BITS'(i_now_ms);
        end
    end

    // evaluate: compares and time sums on the fresh record
    assign rdelay = (i_rdata.report_delay == '0) ? i_cfg.rep_init : i_rdata.report_delay;

    always_comb begin
        ev_rec              = i_rdata;
        ev_rec.report_delay = rdelay;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EVAL) begin
            r_rec              <= ev_rec;
            r_b_exp            <= win_expired(i_rdata.burst_start, r_now, i_cfg.burst_win);
            r_s_exp            <= win_expired(i_rdata.sust_start, r_now, i_cfg.sust_win);
            r_blk_active       <= i_rdata.blocked_until > r_now;
            r_rep_hold         <= i_rdata.next_report > r_now;
            r_t_bblk           <= time_add(r_now, i_cfg.burst_blk);
            r_t_sblk           <= time_add(r_now, i_cfg.sust_blk);
            r_t_rep            <= time_add(r_now, rdelay);
        end
    end

    // update: counters, verdicts and the record written back
    always_comb begin
        upd_rec = r_rec;
        upd_res = '0;
        b_cnt   = r_b_exp ? CNT_W'(1) : sat_inc_cnt(r_rec.burst_count);
        s_cnt   = r_s_exp ? CNT_W'(1) : sat_inc_cnt(r_rec.sust_count);
        over_b  = !r_b_exp && (b_cnt > i_cfg.burst_lim);
        over_s  = !r_s_exp && (s_cnt > i_cfg.sust_lim);
        dbl     = {r_rec.report_delay, 1'b0};
        bt      = sat_inc_tot(r_rec.block_total);
        case (t_op'(r_op))
            OP_CHECK: begin
                if (r_blk_active) begin
                    upd_res.blocked = 1'b1;
                end else begin
                    upd_rec.burst_start = r_b_exp ? r_now : r_rec.burst_start;
                    upd_rec.burst_count = b_cnt;
                    upd_rec.sust_start  = r_s_exp ? r_now : r_rec.sust_start;
                    upd_rec.sust_count  = s_cnt;
                    if (over_b || over_s) begin
                        upd_rec.blocked_until = over_s ? r_t_sblk : r_t_bblk;
                        upd_res.blocked       = 1'b1;
                    end
                end
            end
            default: begin
                upd_rec.block_total = bt;
                if (r_rep_hold) begin
                    upd_rec.supp_total = sat_inc_tot(r_rec.supp_total);
                end else begin
                    upd_res.should_report      = 1'b1;
                    upd_res.blocked_events     = bt;
                    upd_res.suppressed_reports = r_rec.supp_total;
                    upd_rec.supp_total         = '0;
                    upd_rec.next_report        = r_t_rep;
                    upd_rec.report_delay = (dbl > {1'b0, i_cfg.rep_max}) ?
                                           i_cfg.rep_max : dbl[CNT_W-1:0];
                end
            end
        endcase
    end

    assign o_wdata  = upd_rec;
    assign o_result = upd_res;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the dual window per-flow rate limiter.
`timescale 1ns / 1ps

module tb_top;
    import dwrl_pkg::*;

    localparam t_time TIME_MAX = '1;

    // One check or record request as driven on the input channel.
    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] slot;
        logic [NOW_W-1:0]  stamp;
    } t_rl_item;

    // Window bookkeeping after counting one event.
    typedef struct packed {
        t_time            start;
        logic [CNT_W-1:0] cnt;
        logic             over;
    } t_win_state;

    // ------------------------------------------------------------------
    // DUT ports; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic                 i_op        = 1'b0;
    logic [SLOT_W-1:0]    i_slot      = '0;
    logic [NOW_W-1:0]     i_now_ms    = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_blocked;
    logic                 o_should_report;
    logic [TOT_W-1:0]     o_blocked_events;
    logic [TOT_W-1:0]     o_suppressed_reports;

    dual_window_rate_limiter_unit u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_op                 (i_op),
        .i_slot               (i_slot),
        .i_now_ms             (i_now_ms),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_blocked            (o_blocked),
        .o_should_report      (o_should_report),
        .o_blocked_events     (o_blocked_events),
        .o_suppressed_reports (o_suppressed_reports)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow flow table and register copy used for prediction
    // ------------------------------------------------------------------
    t_cfg             lim_cfg;
    t_time            fl_burst_start   [FLOW_SLOTS];
    logic [CNT_W-1:0] fl_burst_cnt     [FLOW_SLOTS];
    t_time            fl_sust_start    [FLOW_SLOTS];
    logic [CNT_W-1:0] fl_sust_cnt      [FLOW_SLOTS];
    t_time            fl_blocked_until [FLOW_SLOTS];
    logic [CNT_W-1:0] fl_rep_delay     [FLOW_SLOTS];
    t_time            fl_next_report   [FLOW_SLOTS];
    logic [TOT_W-1:0] fl_block_total   [FLOW_SLOTS];
    logic [TOT_W-1:0] fl_supp_total    [FLOW_SLOTS];

    t_rl_item pending_items [$];   // filled by the stimulus, drained by the driver
    t_result  verdicts_due  [$];   // predicted verdicts, oldest first

    int      mism_cnt   = 0;
    logic    in_taken   = 1'b0;    // input transfer seen at the last rising edge
    logic    drv_busy   = 1'b0;    // driver holds an item on the channel
    logic    calm       = 1'b0;    // no gaps or stalls in the closing phase
    int      gap_left   = 0;
    int      stall_left = 0;
    t_time   traffic_ms;
    t_rl_item cur_item  = '0;

    // Time sum clamped at the top of the time range.
    function automatic t_time sat_time_sum(input t_time t, input logic [CFG_W-1:0] d);
        if (t_time'(d) > TIME_MAX - t)
            return TIME_MAX;
        return t + t_time'(d);
    endfunction

    // Count one event against a fixed window; restart when unused or run out.
    function automatic t_win_state win_count(input t_time start, input logic [CNT_W-1:0] cnt,
                                             input t_time stamp,
                                             input logic [CFG_W-1:0] len,
                                             input logic [CFG_W-1:0] lim);
        t_win_state w;
        w.start = start;
        w.cnt   = cnt;
        w.over  = 1'b0;
        if (start == '0 || (stamp >= start && (stamp - start) >= t_time'(len))) begin
            w.start = stamp;
            w.cnt   = CNT_W'(1);
        end else begin
            if (cnt != '1)
                w.cnt = cnt + 1'b1;
            w.over = (w.cnt > lim);
        end
        return w;
    endfunction

    // Advance the shadow table by one request and return the expected verdict.
    function automatic t_result predict_verdict(input t_rl_item it);
        t_slot_idx        s = t_slot_idx'(it.slot);
        t_time            t = t_time'(it.stamp);
        t_result          r = '0;
        t_win_state       wb;
        t_win_state       ws;
        logic [CNT_W:0]   dbl;

        if (fl_rep_delay[s] == '0)
            fl_rep_delay[s] = lim_cfg.rep_init;

        if (it.op == OP_CHECK) begin
            if (fl_blocked_until[s] > t) begin
                r.blocked = 1'b1;
                return r;
            end
            wb = win_count(fl_burst_start[s], fl_burst_cnt[s], t,
                           lim_cfg.burst_win, lim_cfg.burst_lim);
            ws = win_count(fl_sust_start[s], fl_sust_cnt[s], t,
                           lim_cfg.sust_win, lim_cfg.sust_lim);
            fl_burst_start[s] = wb.start;
            fl_burst_cnt[s]   = wb.cnt;
            fl_sust_start[s]  = ws.start;
            fl_sust_cnt[s]    = ws.cnt;
            // sustained block time wins when both windows trip
            if (ws.over)
                fl_blocked_until[s] = sat_time_sum(t, lim_cfg.sust_blk);
            else if (wb.over)
                fl_blocked_until[s] = sat_time_sum(t, lim_cfg.burst_blk);
            r.blocked = wb.over | ws.over;
            return r;
        end

        if (fl_block_total[s] != '1)
            fl_block_total[s] = fl_block_total[s] + 1'b1;

        if (fl_next_report[s] > t) begin
            if (fl_supp_total[s] != '1)
                fl_supp_total[s] = fl_supp_total[s] + 1'b1;
            return r;
        end

        r.should_report      = 1'b1;
        r.blocked_events     = fl_block_total[s];
        r.suppressed_reports = fl_supp_total[s];
        fl_supp_total[s]     = '0;
        fl_next_report[s]    = sat_time_sum(t, fl_rep_delay[s]);
        // report spacing doubles up to the ceiling
        dbl = {fl_rep_delay[s], 1'b0};
        if (dbl > {1'b0, lim_cfg.rep_max})
            dbl = {1'b0, lim_cfg.rep_max};
        fl_rep_delay[s] = dbl[CNT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rl_item acc;
        t_result  got;
        t_result  want;

        in_taken = i_in_valid && o_in_ready;
        if (in_taken) begin
            acc.op    = t_op'(i_op);
            acc.slot  = i_slot;
            acc.stamp = i_now_ms;
            verdicts_due.push_back(predict_verdict(acc));
        end

        if (o_out_valid && i_out_ready) begin
            got.blocked            = o_blocked;
            got.should_report      = o_should_report;
            got.blocked_events     = o_blocked_events;
            got.suppressed_reports = o_suppressed_reports;
            if (verdicts_due.size() == 0) begin
                mism_cnt++;
                if (mism_cnt <= 10)
                    $display("%0t: unexpected result transfer blk=%0b rep=%0b ev=%0d supp=%0d",
                             $realtime, got.blocked, got.should_report,
                             got.blocked_events, got.suppressed_reports);
            end else begin
                want = verdicts_due.pop_front();
                if (got.blocked !== want.blocked ||
                    got.should_report !== want.should_report ||
                    got.blocked_events !== want.blocked_events ||
                    got.suppressed_reports !== want.suppressed_reports) begin
                    mism_cnt++;
                    if (mism_cnt <= 10)
                        $display("%0t: exp/act blk %0b/%0b rep %0b/%0b ev %0d/%0d supp %0d/%0d",
                                 $realtime,
                                 want.blocked, got.blocked,
                                 want.should_report, got.should_report,
                                 want.blocked_events, got.blocked_events,
                                 want.suppressed_reports, got.suppressed_reports);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: all inputs change at the falling edge, one update per signal
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic rdy;

        if (in_taken) begin
            drv_busy = 1'b0;
            // sender gap after some transfers
            if (!calm && $urandom_range(0, 3) == 0)
                gap_left = $urandom_range(1, 4);
        end
        if (!drv_busy && i_rst_n) begin
            if (gap_left != 0) begin
                gap_left--;
            end else if (pending_items.size() != 0) begin
                cur_item = pending_items.pop_front();
                drv_busy = 1'b1;
            end
        end
        i_in_valid <= drv_busy;
        i_op       <= cur_item.op;
        i_slot     <= cur_item.slot;
        i_now_ms   <= cur_item.stamp;

        // receiver stalls come in bursts
        if (stall_left != 0) begin
            stall_left--;
            rdy = 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
        end
        i_out_ready <= rdy;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_item(input t_op op, input logic [SLOT_W-1:0] slot,
                                      input t_time stamp);
        t_rl_item it;
        it.op    = op;
        it.slot  = slot;
        it.stamp = stamp;
        pending_items.push_back(it);
    endfunction

    // Block until nothing is queued, in flight or outstanding.
    task automatic wait_idle();
        while (pending_items.size() != 0 || drv_busy || verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
    endtask

    // Write all eight limiter registers; only called while the block is idle.
    task automatic load_limits(input t_cfg c);
        cfg_write(CFG_BURST_WIN, c.burst_win);
        cfg_write(CFG_BURST_LIM, c.burst_lim);
        cfg_write(CFG_BURST_BLK, c.burst_blk);
        cfg_write(CFG_SUST_WIN,  c.sust_win);
        cfg_write(CFG_SUST_LIM,  c.sust_lim);
        cfg_write(CFG_SUST_BLK,  c.sust_blk);
        cfg_write(CFG_REP_INIT,  c.rep_init);
        cfg_write(CFG_REP_MAX,   c.rep_max);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        lim_cfg = c;
    endtask

    function automatic t_cfg rand_limits();
        t_cfg c;
        c.burst_win = CFG_W'($urandom_range(1, 200));
        c.burst_lim = CFG_W'($urandom_range(1, 6));
        c.burst_blk = CFG_W'($urandom_range(0, 400));
        c.sust_win  = CFG_W'($urandom_range(200, 3000));
        c.sust_lim  = CFG_W'($urandom_range(2, 20));
        c.sust_blk  = CFG_W'($urandom_range(0, 3000));
        c.rep_init  = CFG_W'($urandom_range(1, 60));
        c.rep_max   = CFG_W'($urandom_range(1, 500));
        return c;
    endfunction

    // Traffic on a few hot flows with a mostly forward-moving clock; a small
    // share of requests jump anywhere in time or hit a random flow.
    task automatic queue_traffic(input int n);
        logic [SLOT_W-1:0] hot [4];
        logic [SLOT_W-1:0] slot;
        int                pick;

        foreach (hot[k])
            hot[k] = SLOT_W'($urandom);
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                traffic_ms = t_time'({$urandom, $urandom});
            else if (pick < 7)
                traffic_ms = traffic_ms - t_time'($urandom_range(0, 60));
            else if (pick < 15)
                traffic_ms = traffic_ms + t_time'($urandom_range(0, lim_cfg.sust_win));
            else if (pick < 35)
                traffic_ms = traffic_ms + t_time'($urandom_range(0, lim_cfg.burst_win / 3 + 1));
            else
                traffic_ms = traffic_ms + t_time'($urandom_range(0, 3));
            slot = ($urandom_range(0, 9) == 0) ? SLOT_W'($urandom)
                                               : hot[2'($urandom_range(0, 3))];
            push_item(($urandom_range(0, 3) == 0) ? OP_RECORD : OP_CHECK, slot, traffic_ms);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_cfg c;

        lim_cfg = {RST_BURST_WIN, RST_BURST_LIM, RST_BURST_BLK, RST_SUST_WIN,
                   RST_SUST_LIM, RST_SUST_BLK, RST_REP_INIT, RST_REP_MAX};
        foreach (fl_burst_start[k]) begin
            fl_burst_start[k]   = '0;
            fl_burst_cnt[k]     = '0;
            fl_sust_start[k]    = '0;
            fl_sust_cnt[k]      = '0;
            fl_blocked_until[k] = '0;
            fl_rep_delay[k]     = '0;
            fl_next_report[k]   = '0;
            fl_block_total[k]   = '0;
            fl_supp_total[k]    = '0;
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset register values. Zero start stays unused, time at the top of
        // the range saturates the report time, a stamp behind the window start
        // keeps the window open.
        push_item(OP_CHECK,  '0, '0);
        push_item(OP_CHECK,  '0, '0);
        push_item(OP_CHECK,  '1, TIME_MAX);
        push_item(OP_RECORD, '1, TIME_MAX);
        push_item(OP_RECORD, '1, TIME_MAX);
        push_item(OP_RECORD, '1, 40'd5);
        push_item(OP_RECORD, '1, TIME_MAX);
        push_item(OP_CHECK,  '1, 40'd3);
        wait_idle();

        // Tight limits: burst trip with zero block time, then both windows at
        // once (sustained block wins), block expiry and report spacing ceiling.
        c.burst_win = 16'd100;
        c.burst_lim = 16'd2;
        c.burst_blk = 16'd0;
        c.sust_win  = 16'd65535;
        c.sust_lim  = 16'd3;
        c.sust_blk  = 16'd65535;
        c.rep_init  = 16'd65535;
        c.rep_max   = 16'd65535;
        load_limits(c);
        push_item(OP_CHECK,  12'h5A5, 40'd1000);
        push_item(OP_CHECK,  12'h5A5, 40'd1001);
        push_item(OP_CHECK,  12'h5A5, 40'd1002);
        push_item(OP_CHECK,  12'h5A5, 40'd1002);
        push_item(OP_CHECK,  12'h5A5, 40'd2000);
        push_item(OP_RECORD, 12'h5A5, 40'd2000);
        push_item(OP_RECORD, 12'h5A5, 40'd2001);
        push_item(OP_RECORD, 12'h5A5, 40'd67537);
        push_item(OP_CHECK,  12'h5A5, 40'd66537);
        push_item(OP_RECORD, 12'h5A5, 40'd67538);
        wait_idle();

        // Smallest legal settings.
        c.burst_win = 16'd1;
        c.burst_lim = 16'd1;
        c.burst_blk = 16'd0;
        c.sust_win  = 16'd1;
        c.sust_lim  = 16'd1;
        c.sust_blk  = 16'd0;
        c.rep_init  = 16'd1;
        c.rep_max   = 16'd1;
        load_limits(c);
        traffic_ms = t_time'({$urandom, $urandom});
        queue_traffic(75);
        wait_idle();

        // Largest settings everywhere.
        load_limits('1);
        traffic_ms = t_time'({$urandom, $urandom});
        queue_traffic(75);
        wait_idle();

        for (int p = 0; p < 3; p++) begin
            load_limits(rand_limits());
            traffic_ms = t_time'({$urandom, $urandom});
            queue_traffic(75);
            wait_idle();
        end

        // Closing phase: reset values written back, clock near the top of the
        // time range so block and report times saturate; no gaps or stalls.
        load_limits({RST_BURST_WIN, RST_BURST_LIM, RST_BURST_BLK, RST_SUST_WIN,
                     RST_SUST_LIM, RST_SUST_BLK, RST_REP_INIT, RST_REP_MAX});
        calm = 1'b1;
        traffic_ms = TIME_MAX - t_time'(3000);
        queue_traffic(75);

        for (int k = 0; k < 5000 &&
             (pending_items.size() != 0 || drv_busy || verdicts_due.size() != 0); k++)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (verdicts_due.size() != 0 || pending_items.size() != 0 || drv_busy) begin
            mism_cnt++;
            $display("%0t: %0d verdicts never arrived", $realtime, verdicts_due.size());
        end

        if (mism_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, table sweep included.
    initial begin
        #(1_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
